FILE: rtl/core/lhl_pkg.sv
// Shared types and constants for the load level hysteresis block.
// Level codes, configuration register indexes, reset values and the
// effective-threshold struct. No dependencies.
package lhl_pkg;

  typedef logic [1:0] level_t;

  localparam level_t LVL_NORMAL = 2'd0;
  localparam level_t LVL_WARM   = 2'd1;
  localparam level_t LVL_HOT    = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_BUSY_WARM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_HOT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_WARM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_HOT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARM_RISE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HOT_RISE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FALL      = 3'd6;

  localparam logic [6:0]  DEF_BUSY_WARM = 7'd65;
  localparam logic [6:0]  DEF_BUSY_HOT  = 7'd85;
  localparam logic [13:0] DEF_LOAD_WARM = 14'd100;
  localparam logic [13:0] DEF_LOAD_HOT  = 14'd150;
  localparam logic [7:0]  DEF_WARM_RISE = 8'd3;
  localparam logic [7:0]  DEF_HOT_RISE  = 8'd2;
  localparam logic [7:0]  DEF_FALL      = 8'd5;

  // Thresholds as the classifier sees them (zero already replaced)
  typedef struct packed {
    logic [6:0]  busy_warm;
    logic [6:0]  busy_hot;
    logic [13:0] load_warm;
    logic [13:0] load_hot;
  } thresh_t;

endpackage

FILE: rtl/core/lhl_classify.sv
// Candidate level from one registered tick: busy, load and forced levels,
// most severe wins. Depends on lhl_pkg.
module lhl_classify (
  input  lhl_pkg::thresh_t thr,
  input  logic [6:0]       busy_percent,
  input  logic [15:0]      load_hundredths,
  input  logic             load_valid,
  input  logic [1:0]       forced_level,
  output lhl_pkg::level_t  cand_level
);
  import lhl_pkg::*;

  level_t busy_lvl;
  level_t load_lvl;
  level_t forced_lvl;
  level_t max_a;

  always_comb begin
    // hot compare first so a hot threshold below warm still wins
    if (busy_percent >= thr.busy_hot) begin
      busy_lvl = LVL_HOT;
    end else if (busy_percent >= thr.busy_warm) begin
      busy_lvl = LVL_WARM;
    end else begin
      busy_lvl = LVL_NORMAL;
    end

    if (!load_valid) begin
      load_lvl = LVL_NORMAL;
    end else if (load_hundredths >= {2'b00, thr.load_hot}) begin
      load_lvl = LVL_HOT;
    end else if (load_hundredths >= {2'b00, thr.load_warm}) begin
      load_lvl = LVL_WARM;
    end else begin
      load_lvl = LVL_NORMAL;
    end

    // the unused code counts as normal
    forced_lvl = (forced_level == LVL_WARM || forced_level == LVL_HOT) ?
                 forced_level : LVL_NORMAL;

    max_a      = (busy_lvl > forced_lvl) ? busy_lvl : forced_lvl;
    cand_level = (load_lvl > max_a) ? load_lvl : max_a;
  end

endmodule

FILE: rtl/core/load_level_hysteresis_core.sv
// Load level hysteresis: input register, classifier and step logic, result register.
// Throughput: one request per cycle unless the result stream stalls; the held level and streak registers
// update in the cycle the input register hands its request to the result register.
// Reset (rst_n low, synchronous): stages empty, level normal, streaks and
// change count zero, registers back to their reset values. Depends on lhl_pkg.
module load_level_hysteresis_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [lhl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lhl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [6:0] busy_percent, [22:7] load_hundredths,
                                  // [24:23] forced_level, [31:25] zero
  input  logic        in_tuser,   // [0] load_valid
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] load_level, [2] level_changed,
                                  // [34:3] change_count, [39:35] zero
);
  import lhl_pkg::*;

  logic [6:0]  busy_warm_r, busy_hot_r;
  logic [13:0] load_warm_r, load_hot_r;
  logic [7:0]  warm_rise_r, hot_rise_r, fall_r;

  thresh_t     thr;
  logic [7:0]  warm_rise_eff, hot_rise_eff, fall_eff;

  logic        s1_valid_r;
  logic [6:0]  s1_busy_r;
  logic [15:0] s1_load_r;
  logic        s1_lvalid_r;
  logic [1:0]  s1_forced_r;

  logic        out_valid_r;
  logic [39:0] out_data_r;

  level_t      held_r, held_nxt;
  logic [7:0]  rise_r, rise_nxt, fall_str_r, fall_str_nxt;
  logic [31:0] total_r, total_nxt;

  level_t      cand;
  logic        in_fire, advance;
  logic [7:0]  need, rise_bump, fall_bump;

  // a register written as zero acts as its reset value
  always_comb begin
    thr.busy_warm = (busy_warm_r != '0) ? busy_warm_r : DEF_BUSY_WARM;
    thr.busy_hot  = (busy_hot_r  != '0) ? busy_hot_r  : DEF_BUSY_HOT;
    thr.load_warm = (load_warm_r != '0) ? load_warm_r : DEF_LOAD_WARM;
    thr.load_hot  = (load_hot_r  != '0) ? load_hot_r  : DEF_LOAD_HOT;
    warm_rise_eff = (warm_rise_r != '0) ? warm_rise_r : DEF_WARM_RISE;
    hot_rise_eff  = (hot_rise_r  != '0) ? hot_rise_r  : DEF_HOT_RISE;
    fall_eff      = (fall_r      != '0) ? fall_r      : DEF_FALL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_warm_r <= DEF_BUSY_WARM;
      busy_hot_r  <= DEF_BUSY_HOT;
      load_warm_r <= DEF_LOAD_WARM;
      load_hot_r  <= DEF_LOAD_HOT;
      warm_rise_r <= DEF_WARM_RISE;
      hot_rise_r  <= DEF_HOT_RISE;
      fall_r      <= DEF_FALL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BUSY_WARM: busy_warm_r <= cfg_wdata[6:0];
        REG_BUSY_HOT:  busy_hot_r  <= cfg_wdata[6:0];
        REG_LOAD_WARM: load_warm_r <= cfg_wdata;
        REG_LOAD_HOT:  load_hot_r  <= cfg_wdata;
        REG_WARM_RISE: warm_rise_r <= cfg_wdata[7:0];
        REG_HOT_RISE:  hot_rise_r  <= cfg_wdata[7:0];
        REG_FALL:      fall_r      <= cfg_wdata[7:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_busy_r   <= in_tdata[6:0];
      s1_load_r   <= in_tdata[22:7];
      s1_forced_r <= in_tdata[24:23];
      s1_lvalid_r <= in_tuser;
    end
  end

  lhl_classify u_classify (
    .thr             (thr),
    .busy_percent    (s1_busy_r),
    .load_hundredths (s1_load_r),
    .load_valid      (s1_lvalid_r),
    .forced_level    (s1_forced_r),
    .cand_level      (cand)
  );

  always_comb begin
    need         = (held_r == LVL_NORMAL) ? warm_rise_eff : hot_rise_eff;
    rise_bump    = (rise_r == 8'hFF) ? 8'hFF : rise_r + 8'd1;
    fall_bump    = (fall_str_r == 8'hFF) ? 8'hFF : fall_str_r + 8'd1;
    held_nxt     = held_r;
    rise_nxt     = 8'd0;
    fall_str_nxt = 8'd0;
    if (cand > held_r) begin
      if (rise_bump >= need) begin
        held_nxt = held_r + 2'd1;
      end else begin
        rise_nxt = rise_bump;
      end
    end else if (cand < held_r) begin
      if (fall_bump >= fall_eff) begin
        held_nxt = held_r - 2'd1;
      end else begin
        fall_str_nxt = fall_bump;
      end
    end
    total_nxt = (held_nxt != held_r) ? total_r + 32'd1 : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= LVL_NORMAL;
      rise_r     <= 8'd0;
      fall_str_r <= 8'd0;
      total_r    <= 32'd0;
    end else if (advance) begin
      held_r     <= held_nxt;
      rise_r     <= rise_nxt;
      fall_str_r <= fall_str_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {5'd0, total_nxt, (held_nxt != held_r), held_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/core/lhl_checker.sv
// Port-level checker for load_level_hysteresis_core, bound into that module.
// Tracks the last delivered level and count from the result stream alone.
module lhl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  logic        out_fire;
  logic [1:0]  last_level_r;
  logic [31:0] last_count_r;

  assign out_fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 2'd0;
      last_count_r <= 32'd0;
    end else if (out_fire) begin
      last_level_r <= out_tdata[1:0];
      last_count_r <= out_tdata[34:3];
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> out_tdata[34:3] == last_count_r + {31'd0, out_tdata[2]})
    else $error("change count does not follow changed flag");

  a_level_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_tdata[2] |-> out_tdata[1:0] == last_level_r)
    else $error("level moved without changed flag");

  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tdata[2] |->
      (out_tdata[1:0] == last_level_r + 2'd1 || last_level_r == out_tdata[1:0] + 2'd1)
      && out_tdata[1:0] != 2'd3)
    else $error("level moved by more than one step");

endmodule

bind load_level_hysteresis_core lhl_checker u_lhl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
